### sv/aqco_pkg.sv
// Shared types and constants for the quad face classify-and-order unit.
// Used by aqco_core and by the top level; depends on nothing.
`default_nettype none

package aqco_pkg;

    localparam int COORD_W = 32;
    localparam int CORNERS = 4;
    localparam int AXES    = 3;
    localparam int IN_W    = COORD_W * CORNERS * AXES;
    localparam int OUT_W   = 16;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        KIND_REPEATED    = 2'd0,
        KIND_LEFT_RIGHT  = 2'd1,
        KIND_FRONT_BACK  = 2'd2,
        KIND_TOP_BOTTOM  = 2'd3
    } face_kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [CORNERS-1:0]      axis_row_t;
    // quad[axis][corner]
    typedef axis_row_t [AXES-1:0]      quad_t;

    // packs with face_kind in the lowest bits
    typedef struct packed {
        logic [1:0] slot3_src;
        logic [1:0] slot2_src;
        logic [1:0] slot1_src;
        logic [1:0] slot0_src;
        face_kind_t face_kind;
    } face_result_t;

endpackage

`default_nettype wire

### sv/aqco_core.sv
// Combinational classification and corner ordering for one quad face.
// Depends on aqco_pkg for the coordinate and result types.
`default_nettype none

module aqco_core (
    input  aqco_pkg::quad_t        quad,
    output aqco_pkg::face_result_t result
);

    logic signed [aqco_pkg::COORD_W:0]     diff   [aqco_pkg::AXES][aqco_pkg::CORNERS-1];
    logic [aqco_pkg::COORD_W-1:0]          mag    [aqco_pkg::AXES][aqco_pkg::CORNERS-1];
    logic [aqco_pkg::COORD_W-1:0]          spread [aqco_pkg::AXES];
    logic [1:0]                            rank   [aqco_pkg::AXES][aqco_pkg::CORNERS];
    logic [1:0]                            prank  [aqco_pkg::CORNERS];
    logic [1:0]                            srank  [aqco_pkg::CORNERS];
    logic [1:0]                            po     [aqco_pkg::CORNERS];
    logic [1:0]                            p_axis;
    logic [1:0]                            s_axis;
    logic                                  repeated;
    aqco_pkg::face_kind_t                  kind;

    // magnitudes of neighbor differences; differences exact in 33 bits, magnitudes in 32
    always_comb begin
        for (int a = 0; a < aqco_pkg::AXES; a++) begin
            for (int k = 0; k < aqco_pkg::CORNERS - 1; k++) begin
                diff[a][k] = {quad[a][k][aqco_pkg::COORD_W-1], quad[a][k]}
                           - {quad[a][k+1][aqco_pkg::COORD_W-1], quad[a][k+1]};
                mag[a][k]  = diff[a][k][aqco_pkg::COORD_W]
                           ? aqco_pkg::COORD_W'(~diff[a][k] + 1'b1)
                           : diff[a][k][aqco_pkg::COORD_W-1:0];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < aqco_pkg::AXES; a++) begin
            spread[a] = mag[a][0];
            if (mag[a][1] > spread[a]) spread[a] = mag[a][1];
            if (mag[a][2] > spread[a]) spread[a] = mag[a][2];
        end
    end

    // rank every axis in parallel; equal values rank lower index first
    always_comb begin
        for (int a = 0; a < aqco_pkg::AXES; a++) begin
            for (int i = 0; i < aqco_pkg::CORNERS; i++) begin
                rank[a][i] = 2'd0;
                for (int j = 0; j < aqco_pkg::CORNERS; j++) begin
                    if (quad[a][j] < quad[a][i] || (quad[a][j] == quad[a][i] && j < i)) begin
                        rank[a][i] = rank[a][i] + 2'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        repeated = 1'b0;
        for (int i = 0; i < aqco_pkg::CORNERS - 1; i++) begin
            for (int j = i + 1; j < aqco_pkg::CORNERS; j++) begin
                if (quad[0][i] == quad[0][j] && quad[1][i] == quad[1][j]
                        && quad[2][i] == quad[2][j]) begin
                    repeated = 1'b1;
                end
            end
        end
    end

    // smallest spread names the face; ties go x, then y, then z
    always_comb begin
        if (spread[0] <= spread[1] && spread[0] <= spread[2]) begin
            kind   = aqco_pkg::KIND_LEFT_RIGHT;
            p_axis = aqco_pkg::AXIS_Z;
            s_axis = aqco_pkg::AXIS_Y;
        end else if (spread[1] <= spread[2]) begin
            kind   = aqco_pkg::KIND_FRONT_BACK;
            p_axis = aqco_pkg::AXIS_Z;
            s_axis = aqco_pkg::AXIS_X;
        end else begin
            kind   = aqco_pkg::KIND_TOP_BOTTOM;
            p_axis = aqco_pkg::AXIS_Y;
            s_axis = aqco_pkg::AXIS_X;
        end
    end

    always_comb begin
        for (int i = 0; i < aqco_pkg::CORNERS; i++) begin
            prank[i] = rank[p_axis][i];
            srank[i] = rank[s_axis][i];
        end
        for (int r = 0; r < aqco_pkg::CORNERS; r++) begin
            po[r] = 2'd0;
            for (int i = 0; i < aqco_pkg::CORNERS; i++) begin
                if (prank[i] == 2'(r)) po[r] = 2'(i);
            end
        end
    end

    always_comb begin
        if (repeated) begin
            result.face_kind = aqco_pkg::KIND_REPEATED;
            result.slot0_src = 2'd0;
            result.slot1_src = 2'd1;
            result.slot2_src = 2'd2;
            result.slot3_src = 2'd3;
        end else begin
            result.face_kind = kind;
            // upper pair: the one that is also low on the secondary axis goes first
            if (!srank[po[2]][1]) begin
                result.slot0_src = po[2];
                result.slot1_src = po[3];
            end else begin
                result.slot0_src = po[3];
                result.slot1_src = po[2];
            end
            // lower pair: the one that is high on the secondary axis goes first
            if (srank[po[0]][1]) begin
                result.slot2_src = po[0];
                result.slot3_src = po[1];
            end else begin
                result.slot2_src = po[1];
                result.slot3_src = po[0];
            end
        end
    end

endmodule

`default_nettype wire

### sv/axis_quad_classify_and_order_unit.sv
// Top level of the quad face classify-and-order unit: stream ports, input and result registers.
// Depends on aqco_pkg and aqco_core.
`default_nettype none

// Takes one quad face per beat (four corners, x/y/z each signed Q16.16) and returns one
// result beat per face: the face kind and the original indices of the four corners in
// output order. Throughput is one face per clock while m_tready allows; an accepted face passes
// through the input register and then the result register, with the
// classify and rank logic between them. Both registers advance whenever the result
// register is empty or being drained, so s_tready follows m_tready within the cycle.
module axis_quad_classify_and_order_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz: 32 bits each from bit 0 up
    input  wire logic [aqco_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // face_kind[1:0], slot0_src[3:2], slot1_src[5:4], slot2_src[7:6], slot3_src[9:8], zeros
    output logic [aqco_pkg::OUT_W-1:0]       m_tdata
);

    logic                            in_valid_reg;
    logic [aqco_pkg::IN_W-1:0]       in_data_reg;
    logic                            out_valid_reg;
    aqco_pkg::face_result_t          out_data_reg;
    aqco_pkg::face_result_t          out_data_next;
    aqco_pkg::quad_t                 quad;
    logic                            out_adv;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;

    always_comb begin
        for (int c = 0; c < aqco_pkg::CORNERS; c++) begin
            for (int a = 0; a < aqco_pkg::AXES; a++) begin
                quad[a][c] = in_data_reg[(c * aqco_pkg::AXES + a) * aqco_pkg::COORD_W
                                         +: aqco_pkg::COORD_W];
            end
        end
    end

    aqco_core u_core (
        .quad   (quad),
        .result (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (out_adv) out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_data_reg <= s_tdata;
        if (out_adv && in_valid_reg) out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(aqco_pkg::OUT_W - $bits(aqco_pkg::face_result_t)){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

### sv/aqco_checker.sv
// Port-level checks for the quad face classify-and-order unit, bound to its top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module aqco_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [383:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [15:0]  m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // slots are always a permutation of the four corners
    a_slot_perm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:2] != m_tdata[5:4] && m_tdata[3:2] != m_tdata[7:6]
            && m_tdata[3:2] != m_tdata[9:8] && m_tdata[5:4] != m_tdata[7:6]
            && m_tdata[5:4] != m_tdata[9:8] && m_tdata[7:6] != m_tdata[9:8])
        else $error("slot indices repeat");

    // repeated corners keep the given order
    a_same_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[9:2] == 8'b11_10_01_00)
        else $error("repeated-corner face not in given order");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("pad bits of result beat not zero");

endmodule

bind axis_quad_classify_and_order_unit aqco_checker u_aqco_checker (.*);

`default_nettype wire

### tb/axis_quad_classify_and_order_unit_test.sv
// Testbench for axis_quad_classify_and_order_unit: drives quad faces, predicts kind and order.
// Depends on aqco_pkg and the unit's RTL only; self-checking, no external files.
`timescale 1ns / 1ps

module axis_quad_classify_and_order_unit_test;
    import aqco_pkg::*;

    localparam int PHASE_FACES = 270;
    localparam int HOLD_AFTER_RESULTS = 120;
    localparam int HOLD_CYCLES = 64;
    localparam coord_t CMAX = 32'sh7FFF_FFFF;
    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coord_t ONE = 32'sh0001_0000;

    typedef logic [1:0] idx_t;
    typedef idx_t [CORNERS-1:0] order_t;

    class face_scoreboard;
        face_result_t expected_q[$];
        int mismatches;
        int faces_seen;
        int kind_seen[4];

        // largest step between neighboring corners on one axis, exact in 64 bits
        function longint axis_spread(axis_row_t r);
            longint hi;
            longint d;
            hi = 0;
            for (int k = 0; k < CORNERS - 1; k++) begin
                d = longint'($signed(r[k])) - longint'($signed(r[k+1]));
                if (d < 0) d = -d;
                if (d > hi) hi = d;
            end
            return hi;
        endfunction

        // ord[rank] = corner index, ascending, equal values by lower index
        function order_t rank_axis(axis_row_t r);
            order_t ord;
            int rank;
            ord = '0;
            for (int i = 0; i < CORNERS; i++) begin
                rank = 0;
                for (int j = 0; j < CORNERS; j++)
                    if ($signed(r[j]) < $signed(r[i]) || (r[j] == r[i] && j < i)) rank++;
                ord[rank] = idx_t'(i);
            end
            return ord;
        endfunction

        function face_result_t classify_face(quad_t q);
            face_result_t res;
            longint sx, sy, sz;
            logic [1:0] pa, sa;
            order_t po, so;
            bit repeated;
            repeated = 0;
            for (int i = 0; i < CORNERS - 1; i++)
                for (int j = i + 1; j < CORNERS; j++)
                    if (q[AXIS_X][i] == q[AXIS_X][j] && q[AXIS_Y][i] == q[AXIS_Y][j] &&
                        q[AXIS_Z][i] == q[AXIS_Z][j])
                        repeated = 1;
            if (repeated) begin
                res.face_kind = KIND_REPEATED;
                res.slot0_src = 2'd0;
                res.slot1_src = 2'd1;
                res.slot2_src = 2'd2;
                res.slot3_src = 2'd3;
                return res;
            end
            sx = axis_spread(q[AXIS_X]);
            sy = axis_spread(q[AXIS_Y]);
            sz = axis_spread(q[AXIS_Z]);
            // flattest axis names the face; ties go x, then y
            if (sx <= sy && sx <= sz) begin
                res.face_kind = KIND_LEFT_RIGHT;
                pa = AXIS_Z;
                sa = AXIS_Y;
            end else if (sy <= sz) begin
                res.face_kind = KIND_FRONT_BACK;
                pa = AXIS_Z;
                sa = AXIS_X;
            end else begin
                res.face_kind = KIND_TOP_BOTTOM;
                pa = AXIS_Y;
                sa = AXIS_X;
            end
            po = rank_axis(q[pa]);
            so = rank_axis(q[sa]);
            res.slot0_src = (po[2] == so[0] || po[2] == so[1]) ? po[2] : po[3];
            res.slot1_src = (po[2] != res.slot0_src) ? po[2] : po[3];
            res.slot2_src = (po[0] == so[2] || po[0] == so[3]) ? po[0] : po[1];
            res.slot3_src = (po[0] != res.slot2_src) ? po[0] : po[1];
            return res;
        endfunction

        function void note_face(quad_t q);
            face_result_t res;
            res = classify_face(q);
            expected_q.insert(expected_q.size(), res);
            faces_seen++;
            kind_seen[res.face_kind]++;
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            face_result_t exp_res;
            face_result_t got;
            if (expected_q.size() == 0) begin
                $error("result beat 0x%04h with no face outstanding", data);
                mismatches++;
                return;
            end
            exp_res = expected_q.pop_front();
            got = face_result_t'(data[$bits(face_result_t)-1:0]);
            compare_field("face_kind", int'(exp_res.face_kind), int'(got.face_kind));
            compare_field("slot0_src", int'(exp_res.slot0_src), int'(got.slot0_src));
            compare_field("slot1_src", int'(exp_res.slot1_src), int'(got.slot1_src));
            compare_field("slot2_src", int'(exp_res.slot2_src), int'(got.slot2_src));
            compare_field("slot3_src", int'(exp_res.slot3_src), int'(got.slot3_src));
            compare_field("pad", 0, int'(data[OUT_W-1:$bits(face_result_t)]));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz: 32 bits each from bit 0 up
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // face_kind[1:0], slot0_src[3:2], slot1_src[5:4], slot2_src[7:6], slot3_src[9:8], zeros
    logic [OUT_W-1:0] m_tdata;

    face_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int results_taken = 0;
    int hold_left = 0;

    axis_quad_classify_and_order_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // split a face beat into quad[axis][corner]; corners are laid out x, y, z each
    function automatic quad_t unpack_face(logic [IN_W-1:0] v);
        quad_t q;
        for (int c = 0; c < CORNERS; c++)
            for (int a = 0; a < AXES; a++)
                q[a][c] = v[(c * AXES + a) * COORD_W +: COORD_W];
        return q;
    endfunction

    // note every accepted face beat
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_face(unpack_face(s_tdata));
    end

    // check result beats, drive m_tready; one long hold-off to back the unit up
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
            results_taken++;
            if (results_taken == HOLD_AFTER_RESULTS) hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [IN_W-1:0] pack_face(quad_t q);
        logic [IN_W-1:0] v;
        for (int c = 0; c < CORNERS; c++)
            for (int a = 0; a < AXES; a++)
                v[(c * AXES + a) * COORD_W +: COORD_W] = q[a][c];
        return v;
    endfunction

    function automatic coord_t scaled_word();
        coord_t w;
        w = $urandom;
        return w >>> $urandom_range(31);
    endfunction

    function automatic coord_t corner_word();
        case ($urandom_range(5))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic quad_t random_face();
        quad_t q;
        coord_t base;
        int flat, pick, src, dst;
        pick = $urandom_range(99);
        flat = $urandom_range(AXES - 1);
        for (int a = 0; a < AXES; a++) begin
            base = $urandom;
            for (int c = 0; c < CORNERS; c++) begin
                if (pick < 45) begin
                    // near-planar face, one axis almost flat
                    q[a][c] = (a == flat) ? base + coord_t'($urandom_range(3)) :
                                            base + scaled_word();
                end else if (pick < 60) begin
                    q[a][c] = coord_t'($urandom_range(4)) - 2;
                end else if (pick < 90) begin
                    q[a][c] = $urandom;
                end else begin
                    q[a][c] = corner_word();
                end
            end
        end
        // copy one corner onto another
        if (pick >= 60 && pick < 75) begin
            src = $urandom_range(CORNERS - 1);
            dst = (src + 1 + $urandom_range(CORNERS - 2)) % CORNERS;
            for (int a = 0; a < AXES; a++) q[a][dst] = q[a][src];
        end
        return q;
    endfunction

    task automatic drive_face(input quad_t q);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_face(q);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_corners(input coord_t ax, ay, az, bx, by, bz,
                                input coord_t cx, cy, cz, dx, dy, dz);
        quad_t q;
        q[AXIS_X] = {dx, cx, bx, ax};
        q[AXIS_Y] = {dy, cy, by, ay};
        q[AXIS_Z] = {dz, cz, bz, az};
        drive_face(q);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // repeated corners, and one face whose two corners share only x and y
        send_corners(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_corners(0, 0, 0, 1, 0, 0, 2, 0, 0, 2, 0, 0);
        send_corners(5, 6, 7, 1, 2, 3, 9, 9, 9, 5, 6, 7);
        send_corners(0, 0, 0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        send_corners(1, 1, 0, 1, 1, 5, 2, 3, 4, 7, 8, 9);
        // one axis flat, each orientation
        send_corners(0, 0, 5, ONE, 0, 5, ONE, ONE, 5, 0, ONE, 5);
        send_corners(3, 0, 0, 3, ONE, 0, 3, ONE, ONE, 3, 0, ONE);
        send_corners(0, -2, 0, ONE, -2, 0, ONE, -2, ONE, 0, -2, ONE);
        // equal spreads: x wins, then y over z
        send_corners(0, 0, 0, 1, 1, 1, 0, 1, 0, 1, 0, 1);
        send_corners(0, 0, 0, 4, 2, 2, 0, 0, 2, 4, 2, 0);
        // full-range differences need the 33rd bit
        send_corners(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, 0, CMAX, CMIN, -1);
        send_corners(CMIN, CMIN + 1, CMIN, CMAX, CMAX, CMAX,
                     CMIN, CMIN + 1, 0, CMAX, CMAX, -5);
        // ties on the ranking axes fall back to index order
        send_corners(7, 0, 9, 7, 3, 9, 7, 1, 9, 7, 2, 9);
        send_corners(0, 5, 4, 0, 5, 3, 0, 5, 2, 0, 5, 1);
        send_corners(0, 4, 0, 5, 4, 1, 2, 4, 0, 9, 9, 0);
        send_corners(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0);
        send_corners(-100, -200, -300, -101, -250, -300, -99, -180, -301, -102, -210, -299);
        repeat (4) drive_face(random_face());
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            repeat (PHASE_FACES) drive_face(random_face());
            wait_for_results();
        end

        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Checked %0d faces: directed extremes, ties and repeats, then planar, grid,",
                 sb.faces_seen);
        $display("  duplicate and full-range quads under four flow mixes (kinds %0d/%0d/%0d/%0d).",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### files.f
sv/aqco_pkg.sv
sv/aqco_core.sv
sv/axis_quad_classify_and_order_unit.sv
sv/aqco_checker.sv
tb/axis_quad_classify_and_order_unit_test.sv
